>>> rtl/core/cst_pkg.sv
`timescale 1ns / 1ps

package cst_pkg;

  // field widths
  localparam int COORD_W  = 32;
  localparam int CFG_W    = 32;
  localparam int POI_W    = 15;
  localparam int CFG_IDX_W = 2;
  localparam int IDX_W    = 3;
  localparam int VAL_W    = 64;

  // datapath widths
  localparam int DIFF_W   = 33;   // coordinate difference, also den factor width
  localparam int PROD_W   = 66;   // product of two differences
  localparam int SUM_W    = 67;   // sum of two such products
  localparam int DET_W    = 67;   // twice the signed area
  localparam int DETMAG_W = 66;   // its magnitude
  localparam int M_W      = 87;   // entry of Bt' D2 Bt, signed
  localparam int CHUNK_W  = 32;   // partial product chunk
  localparam int TE_W     = 64;   // thickness times modulus
  localparam int TE_CHUNKS  = TE_W / CHUNK_W;
  localparam int MAG_CHUNKS = 3;
  localparam int MAG_W    = MAG_CHUNKS * CHUNK_W;
  localparam int DEN_W    = 98;
  localparam int NUM_W    = 164;
  localparam int DIV_BITS = 63;   // quotient bits below the saturation limit
  localparam int NUM_SHIFT = 14;
  localparam int D_ONE_SHIFT = 17;

  localparam logic [DIFF_W-1:0] FAC_ONE = DIFF_W'(64'h1_0000_0000);
  localparam logic [16:0] POI_ONE = 17'h1_0000;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(5);
  localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_YOUNG   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_POISSON = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_THICK   = CFG_IDX_W'(2);

  // per-element data handed from the setup pipeline to the entry issue
  typedef struct packed {
    logic signed [DIFF_W-1:0] a0;   // y2-y3
    logic signed [DIFF_W-1:0] a1;   // y3-y1
    logic signed [DIFF_W-1:0] a2;   // y1-y2
    logic signed [DIFF_W-1:0] c0;   // x3-x2
    logic signed [DIFF_W-1:0] c1;   // x1-x3
    logic signed [DIFF_W-1:0] c2;   // x2-x1
    logic [TE_W-1:0]          te;
    logic [DEN_W-1:0]         den;
    logic                     dneg;
    logic                     degen;
  } elem_t;

  // one entry entering the divider
  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             last;
    logic             degen;
    logic             neg;
  } div_in_t;

endpackage

>>> rtl/core/cst_element_stiffness.sv
`timescale 1ns / 1ps
// constant strain triangle, plane stress element stiffness
// input channel: in_valid_i / in_stall_o carries the three corner coordinates
//   (signed Q16.16); a transfer happens when valid is high and stall is low
// output channel: out_valid_o / out_stall_i carries 36 entries per element in
//   row-major order, row_index/col_index, Q47.16 value, degenerate and last_entry
// config: cfg_we_i writes cfg_data_i into register cfg_index_i (0 modulus,
//   1 poisson ratio, 2 thickness); write only while no element is in flight
// throughput: one entry per cycle while the output is not stalled, set by the
//   single output port; the setup pipeline buffers up to six further elements
// the entry path is 8 stages of products and sums, then a 63-stage restoring
//   divider (one quotient bit per stage) and two rounding/saturation stages
// reset clears all valid bits and loads modulus 1, ratio 0, thickness 1.0
// a stalled output freezes the whole entry pipeline; nothing is dropped and
//   the setup pipeline keeps filling until it backs up onto in_stall_o
module cst_element_stiffness (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [cst_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [cst_pkg::CFG_W-1:0]           cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [cst_pkg::COORD_W-1:0]  first_x_i,
  input  logic signed [cst_pkg::COORD_W-1:0]  first_y_i,
  input  logic signed [cst_pkg::COORD_W-1:0]  second_x_i,
  input  logic signed [cst_pkg::COORD_W-1:0]  second_y_i,
  input  logic signed [cst_pkg::COORD_W-1:0]  third_x_i,
  input  logic signed [cst_pkg::COORD_W-1:0]  third_y_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [cst_pkg::IDX_W-1:0]           row_index_o,
  output logic [cst_pkg::IDX_W-1:0]           col_index_o,
  output logic signed [cst_pkg::VAL_W-1:0]    stiffness_value_o,
  output logic                                degenerate_o,
  output logic                                last_entry_o
);
  import cst_pkg::*;

  // configuration registers
  logic [CFG_W-1:0] young_q;
  logic [POI_W-1:0] poisson_q;
  logic [CFG_W-1:0] thick_q;

  // pipeline hookup
  logic             en_e;
  logic             elem_valid, elem_ready;
  elem_t            elem;
  logic             div_valid;
  div_in_t          div_in;
  logic [VAL_W-1:0] value;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      young_q   <= CFG_W'(1);
      poisson_q <= '0;
      thick_q   <= CFG_W'(65536);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_YOUNG:   young_q   <= cfg_data_i;
        REG_POISSON: poisson_q <= cfg_data_i[POI_W-1:0];
        REG_THICK:   thick_q   <= cfg_data_i;
        default:     ;  // unused index, ignored
      endcase
    end
  end

  // the entry pipeline and divider move together unless the output is stalled
  assign en_e = !(out_valid_o && out_stall_i);

  // per element setup: differences, signed area, denominator
  cst_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .first_x_i    (first_x_i),
    .first_y_i    (first_y_i),
    .second_x_i   (second_x_i),
    .second_y_i   (second_y_i),
    .third_x_i    (third_x_i),
    .third_y_i    (third_y_i),
    .young_i      (young_q),
    .poisson_i    (poisson_q),
    .thick_i      (thick_q),
    .elem_ready_i (elem_ready),
    .elem_valid_o (elem_valid),
    .elem_o       (elem)
  );

  // element hold, entry issue and numerator
  cst_entry u_entry (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en_e),
    .elem_valid_i (elem_valid),
    .elem_i       (elem),
    .poisson_i    (poisson_q),
    .elem_ready_o (elem_ready),
    .div_valid_o  (div_valid),
    .div_o        (div_in)
  );

  // divide, round, saturate, output register
  cst_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en_e),
    .in_valid_i  (div_valid),
    .in_i        (div_in),
    .out_valid_o (out_valid_o),
    .row_o       (row_index_o),
    .col_o       (col_index_o),
    .value_o     (value),
    .degen_o     (degenerate_o),
    .last_o      (last_entry_o)
  );

  assign stiffness_value_o = $signed(value);

`ifndef SYNTHESIS
  a_last_corner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_entry_o) |-> (row_index_o == LAST_IDX && col_index_o == LAST_IDX))
    else $error("last entry flagged away from the final corner");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && degenerate_o) |-> (stiffness_value_o == '0))
    else $error("degenerate element with nonzero entry");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (row_index_o <= LAST_IDX && col_index_o <= LAST_IDX))
    else $error("entry index out of range");
`endif

endmodule

>>> rtl/core/cst_front.sv
`timescale 1ns / 1ps

module cst_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [cst_pkg::COORD_W-1:0] first_x_i,
  input  logic signed [cst_pkg::COORD_W-1:0] first_y_i,
  input  logic signed [cst_pkg::COORD_W-1:0] second_x_i,
  input  logic signed [cst_pkg::COORD_W-1:0] second_y_i,
  input  logic signed [cst_pkg::COORD_W-1:0] third_x_i,
  input  logic signed [cst_pkg::COORD_W-1:0] third_y_i,
  input  logic [cst_pkg::CFG_W-1:0]     young_i,
  input  logic [cst_pkg::POI_W-1:0]     poisson_i,
  input  logic [cst_pkg::CFG_W-1:0]     thick_i,
  input  logic                          elem_ready_i,
  output logic                          elem_valid_o,
  output cst_pkg::elem_t                elem_o
);
  import cst_pkg::*;

  localparam int STAGES = 6;

  typedef struct packed {
    logic signed [DIFF_W-1:0] a0;
    logic signed [DIFF_W-1:0] a1;
    logic signed [DIFF_W-1:0] a2;
    logic signed [DIFF_W-1:0] c0;
    logic signed [DIFF_W-1:0] c1;
    logic signed [DIFF_W-1:0] c2;
  } dif_t;

  logic [STAGES-1:0] v_q;
  logic              en;

  dif_t                      dif_q [STAGES];
  logic [TE_W-1:0]           te_q  [STAGES-1];
  logic signed [PROD_W-1:0]  pa_q, pb_q;
  logic [2*POI_W-1:0]        nsq_q;
  logic signed [DET_W-1:0]   det_q;
  logic [DIFF_W-1:0]         fac3_q, fac4_q;
  logic [DET_W-1:0]          det_abs;
  logic [DETMAG_W-1:0]       mag_q;
  logic [2:0]                dneg_q, degen_q;
  logic [PROD_W-1:0]         pp0_q, pp1_q;
  logic [DEN_W-1:0]          den_q;

  assign en         = !v_q[STAGES-1] || elem_ready_i;
  assign in_stall_o = !en;
  assign det_abs    = det_q[DET_W-1] ? DET_W'(-det_q) : DET_W'(det_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[STAGES-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // coordinate differences
      dif_q[0].a0 <= DIFF_W'(second_y_i) - DIFF_W'(third_y_i);
      dif_q[0].a1 <= DIFF_W'(third_y_i) - DIFF_W'(first_y_i);
      dif_q[0].a2 <= DIFF_W'(first_y_i) - DIFF_W'(second_y_i);
      dif_q[0].c0 <= DIFF_W'(third_x_i) - DIFF_W'(second_x_i);
      dif_q[0].c1 <= DIFF_W'(first_x_i) - DIFF_W'(third_x_i);
      dif_q[0].c2 <= DIFF_W'(second_x_i) - DIFF_W'(first_x_i);
      for (int k = 1; k < STAGES; k++) dif_q[k] <= dif_q[k-1];
      // area products, material scale
      pa_q     <= dif_q[0].c2 * dif_q[0].a1;
      pb_q     <= dif_q[0].c1 * dif_q[0].a2;
      te_q[0]  <= thick_i * young_i;
      nsq_q    <= poisson_i * poisson_i;
      for (int k = 1; k < STAGES-1; k++) te_q[k] <= te_q[k-1];
      // twice the signed area
      det_q    <= DET_W'(pa_q) - DET_W'(pb_q);
      fac3_q   <= FAC_ONE - DIFF_W'(nsq_q);
      // sign and magnitude
      mag_q      <= det_abs[DETMAG_W-1:0];
      dneg_q[0]  <= det_q[DET_W-1];
      degen_q[0] <= (det_q == '0);
      fac4_q     <= fac3_q;
      // denominator partial products
      pp0_q      <= mag_q[DIFF_W-1:0] * fac4_q;
      pp1_q      <= mag_q[DETMAG_W-1:DIFF_W] * fac4_q;
      dneg_q[1]  <= dneg_q[0];
      degen_q[1] <= degen_q[0];
      // denominator
      den_q      <= DEN_W'(pp0_q) + (DEN_W'(pp1_q) << DIFF_W);
      dneg_q[2]  <= dneg_q[1];
      degen_q[2] <= degen_q[1];
    end
  end

  assign elem_valid_o = v_q[STAGES-1];
  assign elem_o.a0    = dif_q[STAGES-1].a0;
  assign elem_o.a1    = dif_q[STAGES-1].a1;
  assign elem_o.a2    = dif_q[STAGES-1].a2;
  assign elem_o.c0    = dif_q[STAGES-1].c0;
  assign elem_o.c1    = dif_q[STAGES-1].c1;
  assign elem_o.c2    = dif_q[STAGES-1].c2;
  assign elem_o.te    = te_q[STAGES-2];
  assign elem_o.den   = den_q;
  assign elem_o.dneg  = dneg_q[2];
  assign elem_o.degen = degen_q[2];

endmodule

>>> rtl/core/cst_entry.sv
`timescale 1ns / 1ps

module cst_entry (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      elem_valid_i,
  input  cst_pkg::elem_t            elem_i,
  input  logic [cst_pkg::POI_W-1:0] poisson_i,
  output logic                      elem_ready_o,
  output logic                      div_valid_o,
  output cst_pkg::div_in_t          div_o
);
  import cst_pkg::*;

  localparam int STAGES = 8;

  typedef struct packed {
    logic signed [DIFF_W-1:0] b0;
    logic signed [DIFF_W-1:0] b1;
    logic signed [DIFF_W-1:0] b2;
  } bcol_t;

  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             last;
    logic             degen;
    logic             neg;
    logic [TE_W-1:0]  te;
    logic [DEN_W-1:0] den;
  } epay_t;

  // column of Bt for one degree of freedom
  function automatic bcol_t col_sel(logic [IDX_W-1:0] idx, elem_t e);
    logic signed [DIFF_W-1:0] a, c;
    bcol_t r;
    case (idx[IDX_W-1:1])
      2'd0:    begin a = e.a0; c = e.c0; end
      2'd1:    begin a = e.a1; c = e.c1; end
      default: begin a = e.a2; c = e.c2; end
    endcase
    if (idx[0]) begin
      r.b0 = '0; r.b1 = c; r.b2 = a;
    end else begin
      r.b0 = a; r.b1 = '0; r.b2 = c;
    end
    return r;
  endfunction

  elem_t            elem_q;
  logic             elem_valid_q;
  logic [IDX_W-1:0] row_q, col_q;
  logic             issue_last;
  logic [STAGES-1:0] ev_q;
  epay_t            pay_q [STAGES];

  bcol_t                    bp_q, bq_q;
  logic signed [PROD_W-1:0] p00_q, p11_q, p01_q, p10_q, p22_q, p22b_q;
  logic signed [SUM_W-1:0]  s0_q, s1_q;
  logic signed [M_W-1:0]    t0_q, t1_q, t2_q, m_q;
  logic [M_W-1:0]           m_abs;
  logic [MAG_W-1:0]         mag_q;
  logic [2:0]               mneg_q;
  logic [2*CHUNK_W-1:0]     pp_q [TE_CHUNKS*MAG_CHUNKS];
  logic [NUM_W-1:0]         num_q, num_d;

  assign issue_last   = (row_q == LAST_IDX) && (col_q == LAST_IDX);
  assign elem_ready_o = !elem_valid_q || (en_i && issue_last);
  assign m_abs        = m_q[M_W-1] ? M_W'(-m_q) : M_W'(m_q);

  // element hold and entry counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elem_valid_q <= 1'b0;
      row_q        <= '0;
      col_q        <= '0;
    end else if (elem_ready_o && elem_valid_i) begin
      elem_valid_q <= 1'b1;
      row_q        <= '0;
      col_q        <= '0;
    end else if (en_i && elem_valid_q) begin
      if (issue_last) begin
        elem_valid_q <= 1'b0;
      end else if (col_q == LAST_IDX) begin
        col_q <= '0;
        row_q <= row_q + IDX_W'(1);
      end else begin
        col_q <= col_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (elem_ready_o && elem_valid_i) elem_q <= elem_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_q <= '0;
    end else if (en_i) begin
      ev_q <= {ev_q[STAGES-2:0], elem_valid_q};
    end
  end

  always_comb begin
    num_d = '0;
    for (int i = 0; i < TE_CHUNKS; i++) begin
      for (int j = 0; j < MAG_CHUNKS; j++) begin
        num_d = num_d + (NUM_W'(pp_q[i*MAG_CHUNKS+j]) << (CHUNK_W*(i+j) + NUM_SHIFT));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // issue: pick the two columns
      bp_q           <= col_sel(row_q, elem_q);
      bq_q           <= col_sel(col_q, elem_q);
      pay_q[0].row   <= row_q;
      pay_q[0].col   <= col_q;
      pay_q[0].last  <= issue_last;
      pay_q[0].degen <= elem_q.degen;
      pay_q[0].neg   <= elem_q.dneg;
      pay_q[0].te    <= elem_q.te;
      pay_q[0].den   <= elem_q.den;
      for (int k = 1; k < STAGES; k++) pay_q[k] <= pay_q[k-1];
      // difference products
      p00_q <= bp_q.b0 * bq_q.b0;
      p11_q <= bp_q.b1 * bq_q.b1;
      p01_q <= bp_q.b0 * bq_q.b1;
      p10_q <= bp_q.b1 * bq_q.b0;
      p22_q <= bp_q.b2 * bq_q.b2;
      // pair sums
      s0_q   <= SUM_W'(p00_q) + SUM_W'(p11_q);
      s1_q   <= SUM_W'(p01_q) + SUM_W'(p10_q);
      p22b_q <= p22_q;
      // material weights
      t0_q <= M_W'(s0_q) <<< D_ONE_SHIFT;
      t1_q <= s1_q * $signed({2'b0, poisson_i, 1'b0});
      t2_q <= p22b_q * $signed({1'b0, POI_ONE - 17'(poisson_i)});
      // entry of the unscaled product
      m_q  <= t0_q + t1_q + t2_q;
      // magnitude and result sign
      mag_q     <= MAG_W'(m_abs);
      mneg_q[0] <= m_q[M_W-1];
      mneg_q[1] <= mneg_q[0];
      mneg_q[2] <= mneg_q[1];
      // scale partial products
      for (int i = 0; i < TE_CHUNKS; i++) begin
        for (int j = 0; j < MAG_CHUNKS; j++) begin
          pp_q[i*MAG_CHUNKS+j] <= pay_q[5].te[i*CHUNK_W +: CHUNK_W]
                                  * mag_q[j*CHUNK_W +: CHUNK_W];
        end
      end
      // numerator
      num_q <= num_d;
    end
  end

  assign div_valid_o = ev_q[STAGES-1];
  assign div_o.num   = num_q;
  assign div_o.den   = pay_q[STAGES-1].den;
  assign div_o.row   = pay_q[STAGES-1].row;
  assign div_o.col   = pay_q[STAGES-1].col;
  assign div_o.last  = pay_q[STAGES-1].last;
  assign div_o.degen = pay_q[STAGES-1].degen;
  assign div_o.neg   = pay_q[STAGES-1].neg ^ mneg_q[2];

endmodule

>>> rtl/core/cst_div.sv
`timescale 1ns / 1ps

module cst_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      in_valid_i,
  input  cst_pkg::div_in_t          in_i,
  output logic                      out_valid_o,
  output logic [cst_pkg::IDX_W-1:0] row_o,
  output logic [cst_pkg::IDX_W-1:0] col_o,
  output logic [cst_pkg::VAL_W-1:0] value_o,
  output logic                      degen_o,
  output logic                      last_o
);
  import cst_pkg::*;

  typedef struct packed {
    logic [NUM_W-1:0]    rem;
    logic [DIV_BITS-1:0] quo;
    logic                ovf;
    logic [DEN_W-1:0]    den;
    logic [IDX_W-1:0]    row;
    logic [IDX_W-1:0]    col;
    logic                last;
    logic                degen;
    logic                neg;
  } dstage_t;

  logic [DIV_BITS:0] v_q;
  dstage_t           st_q [DIV_BITS+1];

  logic             r1_v_q;
  logic [VAL_W-1:0] qr_q;
  logic             sat_q, neg_q, degen_q, last_q;
  logic [IDX_W-1:0] row_q, col_q;
  logic             rnd;
  dstage_t          fin;

  logic             out_v_q;
  logic [VAL_W-1:0] val_q;
  logic [IDX_W-1:0] orow_q, ocol_q;
  logic             odegen_q, olast_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      r1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en_i) begin
      v_q     <= {v_q[DIV_BITS-1:0], in_valid_i};
      r1_v_q  <= v_q[DIV_BITS];
      out_v_q <= r1_v_q;
    end
  end

  // saturation check up front
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0].rem   <= in_i.num;
      st_q[0].quo   <= '0;
      st_q[0].ovf   <= (in_i.num >= NUM_W'({in_i.den, {DIV_BITS{1'b0}}}));
      st_q[0].den   <= in_i.den;
      st_q[0].row   <= in_i.row;
      st_q[0].col   <= in_i.col;
      st_q[0].last  <= in_i.last;
      st_q[0].degen <= in_i.degen;
      st_q[0].neg   <= in_i.neg;
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar k = 0; k < DIV_BITS; k++) begin : g_stage
    localparam int B = DIV_BITS - 1 - k;
    logic [NUM_W:0] diff;
    dstage_t        nxt;
    always_comb begin
      diff = {1'b0, st_q[k].rem} - {1'b0, NUM_W'(st_q[k].den) << B};
      nxt  = st_q[k];
      if (!diff[NUM_W]) begin
        nxt.rem    = diff[NUM_W-1:0];
        nxt.quo[B] = 1'b1;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) st_q[k+1] <= nxt;
    end
  end

  assign fin = st_q[DIV_BITS];
  assign rnd = {fin.rem[DEN_W-1:0], 1'b0} >= {1'b0, fin.den};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // round half up
      qr_q    <= {1'b0, fin.quo} + VAL_W'(rnd);
      sat_q   <= fin.ovf;
      neg_q   <= fin.neg;
      degen_q <= fin.degen;
      last_q  <= fin.last;
      row_q   <= fin.row;
      col_q   <= fin.col;
      // sign and saturation
      if (degen_q)                   val_q <= '0;
      else if (sat_q || qr_q[VAL_W-1]) val_q <= neg_q ? VAL_MIN : VAL_MAX;
      else if (neg_q)                val_q <= -qr_q;
      else                           val_q <= qr_q;
      orow_q   <= row_q;
      ocol_q   <= col_q;
      odegen_q <= degen_q;
      olast_q  <= last_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign row_o       = orow_q;
  assign col_o       = ocol_q;
  assign value_o     = val_q;
  assign degen_o     = odegen_q;
  assign last_o      = olast_q;

endmodule
